@@ rtl/core/pfc_pkg.sv @@
// Shared types, constants and lookup functions for the Playfair digraph cipher.
package pfc_pkg;

    localparam int unsigned SQ         = 5;
    localparam int unsigned APB_ADDR_W = 5;

    localparam logic [4:0] FILLER_X = 5'd23;
    localparam logic [4:0] CODE_J   = 5'd9;
    localparam logic [4:0] CODE_I   = 5'd8;

    localparam logic [2:0] NUM_KEY_ROWS = 3'd5;

    typedef logic [24:0]      t_key_row;
    typedef t_key_row [4:0]   t_key;

    // Power-on square: ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ
    localparam t_key KEY_RESET = {25'd27025109, 25'd21613104, 25'd16201099,
                                  25'd10755269, 25'd4294688};

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] b;
        logic       decrypt;
        logic       last_pair;
    } t_pair;

    typedef struct packed {
        logic  valid;
        t_pair pair;
    } t_push;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } t_loc;

    function automatic logic [4:0] fold_j(logic [4:0] c);
        return (c == CODE_J) ? CODE_I : c;
    endfunction

    // Position of a letter; last match in row-major order, else row 0 col 0.
    function automatic t_loc locate(t_key k, logic [4:0] ch);
        t_loc r;
        r = '0;
        for (int i = 0; i < SQ; i++) begin
            for (int j = 0; j < SQ; j++) begin
                if (k[i][5*j +: 5] == ch) begin
                    r.row = 3'(i);
                    r.col = 3'(j);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] sq_cell(t_key k, logic [2:0] r, logic [2:0] c);
        t_key_row row;
        t_key_row sh;
        row = k[r];
        sh  = row >> (5'(c) * 5'd5);
        return sh[4:0];
    endfunction

    // One step around a row or column, right/down or left/up.
    function automatic logic [2:0] step5(logic [2:0] v, logic dec);
        logic [2:0] r;
        if (dec) begin
            r = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end else begin
            r = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/pfc_if.sv @@
// Valid/ready channel interfaces for letter input and substituted output.
interface pfc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [4:0] letter;
    logic       last_letter;

    modport source (output valid, output action, output letter, output last_letter,
                    input ready);
    modport sink   (input valid, input action, input letter, input last_letter,
                    output ready);
endinterface

interface pfc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] out_letter;
    logic       end_of_text;

    modport source (output valid, output out_letter, output end_of_text, input ready);
    modport sink   (input valid, input out_letter, input end_of_text, output ready);
endinterface

@@ rtl/core/playfair_digraph_cipher.sv @@
// Top level of the Playfair digraph cipher with its APB key-square registers.
//
// Letters (A=0..Z=25, J taken as I) enter one beat per cycle on i_letter_in
// while it is ready, with an action bit (0 encrypt, 1 decrypt) and a
// last-letter mark. The front end pairs letters into digraphs (encrypt splits
// a doubled letter with X; a lone final letter is padded with X in either
// mode) and pushes them into a FIFO_DEPTH-entry queue. The back end locates
// both letters in the 5x5 key square in one stage, substitutes in the next,
// and sends the two resulting letters as two beats on o_letter_out;
// end_of_text rides on the second letter of the final pair. The output moves
// one beat per cycle while o_letter_out.ready is high, so ordinary text, two
// letters in for two beats out, keeps pace with the input; a run of doubled
// letters while encrypting (or a padded final letter) turns one input letter
// into a whole pair, and the output port then limits the stream. A completed
// pair passes through the queue, the position stage and the output stage
// before its first output beat appears. A doubled final letter while
// encrypting yields two pairs and holds the input off until the second pair
// is pushed. The key square is five 25-bit registers at byte addresses 0, 4,
// 8, 12, 16 (column 0 in bits 4:0; paddr[1:0] is ignored); it resets to
// ABCDE/FGHIK/LMNOP/QRSTU/VWXYZ and should be written only while the block is
// idle. Writes to addresses 20 and above are dropped and read back as zero.
module playfair_digraph_cipher #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pfc_in_if.sink                         i_letter_in,
    pfc_out_if.source                      o_letter_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pfc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    pfc_pkg::t_key  r_key;
    pfc_pkg::t_push push;
    pfc_pkg::t_pair head;
    logic           full;
    logic           empty;
    logic           pop;
    logic [2:0]     reg_idx;
    logic           idx_ok;

    // APB register file for the key square
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign idx_ok  = (reg_idx < pfc_pkg::NUM_KEY_ROWS);
    assign prdata  = idx_ok ? {7'd0, r_key[reg_idx]} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= pfc_pkg::KEY_RESET;
        end else if (psel && penable && pwrite && pready && idx_ok) begin
            r_key[reg_idx] <= pwdata[24:0];
        end
    end

    pfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_letter_in (i_letter_in),
        .i_full      (full),
        .o_push      (push)
    );

    pfc_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    pfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (r_key),
        .i_head       (head),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_letter_out (o_letter_out)
    );

endmodule

@@ rtl/core/pfc_front.sv @@
// Front end: accepts letters, tracks the held letter and forms digraphs.
module pfc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pfc_in_if.sink         i_letter_in,
    input  logic           i_full,
    output pfc_pkg::t_push o_push
);

    logic [4:0]     r_held;
    logic           r_held_v;
    pfc_pkg::t_pair r_pend;
    logic           r_pend_v;

    logic [4:0]     n_held;
    logic           n_held_v;
    pfc_pkg::t_pair n_pend;
    logic           n_pend_v;

    logic [4:0] ch;
    logic       acc;
    logic       dec;
    logic       last;

    assign i_letter_in.ready = !r_pend_v && !i_full;
    assign acc  = i_letter_in.valid && i_letter_in.ready;
    assign ch   = pfc_pkg::fold_j(i_letter_in.letter);
    assign dec  = i_letter_in.action;
    assign last = i_letter_in.last_letter;

    always_comb begin
        n_held      = r_held;
        n_held_v    = r_held_v;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v && i_full;
        o_push.valid = r_pend_v && !i_full;
        o_push.pair  = r_pend;
        if (acc) begin
            if (!r_held_v) begin
                if (last) begin
                    o_push.valid = 1'b1;
                    o_push.pair  = '{a: ch, b: pfc_pkg::FILLER_X, decrypt: dec,
                                     last_pair: 1'b1};
                end else begin
                    n_held   = ch;
                    n_held_v = 1'b1;
                end
            end else if (!dec && r_held == ch) begin
                // doubled letter: split with filler X
                o_push.valid = 1'b1;
                o_push.pair  = '{a: r_held, b: pfc_pkg::FILLER_X, decrypt: 1'b0,
                                 last_pair: 1'b0};
                if (last) begin
                    n_pend   = '{a: ch, b: pfc_pkg::FILLER_X, decrypt: 1'b0,
                                 last_pair: 1'b1};
                    n_pend_v = 1'b1;
                    n_held   = '0;
                    n_held_v = 1'b0;
                end else begin
                    n_held = ch;
                end
            end else begin
                o_push.valid = 1'b1;
                o_push.pair  = '{a: r_held, b: ch, decrypt: dec, last_pair: last};
                n_held       = '0;
                n_held_v     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

@@ rtl/core/pfc_queue.sv @@
// Small FIFO of digraphs between front end and substitution back end.
module pfc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pfc_pkg::t_push i_push,
    output logic           o_full,
    input  logic           i_pop,
    output pfc_pkg::t_pair o_head,
    output logic           o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pfc_pkg::t_pair r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.pair;
        end
    end

endmodule

@@ rtl/core/pfc_back.sv @@
// Back end: locates a digraph in the key square and emits two substituted letters.
module pfc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pfc_pkg::t_key  i_key,
    input  pfc_pkg::t_pair i_head,
    input  logic           i_empty,
    output logic           o_pop,
    pfc_out_if.source      o_letter_out
);

    // position stage
    pfc_pkg::t_loc r_loc_a;
    pfc_pkg::t_loc r_loc_b;
    logic          r_pos_dec;
    logic          r_pos_last;
    logic          r_pos_v;

    // output stage: two beats per pair
    logic [4:0] r_oa;
    logic [4:0] r_ob;
    logic       r_out_last;
    logic       r_out_v;
    logic       r_beat;

    logic       out_done;
    logic       out_open;
    logic       pos_move;
    logic [4:0] oa;
    logic [4:0] ob;

    assign out_done = r_out_v && r_beat && o_letter_out.ready;
    assign out_open = !r_out_v || out_done;
    assign pos_move = r_pos_v && out_open;
    assign o_pop    = !i_empty && (!r_pos_v || pos_move);

    assign o_letter_out.valid       = r_out_v;
    assign o_letter_out.out_letter  = r_beat ? r_ob : r_oa;
    assign o_letter_out.end_of_text = r_beat && r_out_last;

    always_comb begin
        if (r_loc_a.row == r_loc_b.row) begin
            oa = pfc_pkg::sq_cell(i_key, r_loc_a.row, pfc_pkg::step5(r_loc_a.col, r_pos_dec));
            ob = pfc_pkg::sq_cell(i_key, r_loc_b.row, pfc_pkg::step5(r_loc_b.col, r_pos_dec));
        end else if (r_loc_a.col == r_loc_b.col) begin
            oa = pfc_pkg::sq_cell(i_key, pfc_pkg::step5(r_loc_a.row, r_pos_dec), r_loc_a.col);
            ob = pfc_pkg::sq_cell(i_key, pfc_pkg::step5(r_loc_b.row, r_pos_dec), r_loc_b.col);
        end else begin
            oa = pfc_pkg::sq_cell(i_key, r_loc_a.row, r_loc_b.col);
            ob = pfc_pkg::sq_cell(i_key, r_loc_b.row, r_loc_a.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_v <= 1'b0;
            r_out_v <= 1'b0;
            r_beat  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos_v <= 1'b1;
            end else if (pos_move) begin
                r_pos_v <= 1'b0;
            end
            if (pos_move) begin
                r_out_v <= 1'b1;
                r_beat  <= 1'b0;
            end else if (out_done) begin
                r_out_v <= 1'b0;
                r_beat  <= 1'b0;
            end else if (r_out_v && o_letter_out.ready) begin
                r_beat <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_loc_a    <= pfc_pkg::locate(i_key, i_head.a);
            r_loc_b    <= pfc_pkg::locate(i_key, i_head.b);
            r_pos_dec  <= i_head.decrypt;
            r_pos_last <= i_head.last_pair;
        end
        if (pos_move) begin
            r_oa       <= oa;
            r_ob       <= ob;
            r_out_last <= r_pos_last;
        end
    end

endmodule
